### rtl/core/sbfp_pkg.sv
// ----------------------------------------------------------------------------
// sbfp_pkg
// Shared types, sizes and helpers of the sbus frame parser.
// ----------------------------------------------------------------------------
package sbfp_pkg;

	localparam int FRAME_BYTES = 25;
	localparam int CHANNELS    = 16;
	localparam int CH_BITS     = 11;
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	localparam int CH_W        = $clog2(CHANNELS);
	localparam int CNT_W       = 32;
	localparam int ACC_W       = CH_BITS + 7;
	localparam int NBITS_W     = $clog2(ACC_W + 1);

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CH_W-1:0]    ch_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [ACC_W-1:0]   acc_t;
	typedef logic [NBITS_W-1:0] nbits_t;

	localparam logic [7:0] START_RESET = 8'h0F;

	// positions inside a frame, counted from the frame head
	localparam idx_t HEAD_POS  = idx_t'(0);
	localparam idx_t DATA_POS  = idx_t'(1);
	localparam idx_t FLAG_POS  = idx_t'(FRAME_BYTES - 2);
	localparam idx_t LAST_POS  = idx_t'(FRAME_BYTES - 1);
	localparam idx_t FULL_FILL = idx_t'(FRAME_BYTES);
	localparam ch_t  LAST_CH   = ch_t'(CHANNELS - 1);

	// request from the sequencer to the frame store
	typedef struct packed {
		logic       wr;
		logic       rd;
		idx_t       pos;
		logic [7:0] wdata;
		logic       adv;
		idx_t       adv_by;
	} store_req_t;

	function automatic logic end_byte_ok(input logic [7:0] b);
		logic ok;
		case (b) inside
			8'h00, 8'h04, 8'h14, 8'h24, 8'h34: ok = 1'b1;
			default:                           ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

### rtl/core/sbfp_store.sv
// ----------------------------------------------------------------------------
// sbfp_store
// Circular frame buffer: one synchronous memory addressed relative to a head
// pointer, so a resync moves the head instead of copying bytes.
// ----------------------------------------------------------------------------
module sbfp_store (
	input  logic                clk,
	input  logic                arst_n,
	input  sbfp_pkg::store_req_t req,
	output logic [7:0]          rdata
);

	logic [7:0]                 mem [sbfp_pkg::FRAME_BYTES];
	sbfp_pkg::idx_t             head_q;
	sbfp_pkg::idx_t             addr;
	sbfp_pkg::idx_t             head_next;
	logic [sbfp_pkg::IDX_W:0]   sum;
	logic [sbfp_pkg::IDX_W:0]   head_sum;

	// wrap head + position back into the buffer
	always_comb begin
		sum = {1'b0, head_q} + {1'b0, req.pos};
		if (sum >= (sbfp_pkg::IDX_W + 1)'(sbfp_pkg::FRAME_BYTES)) begin
			addr = sbfp_pkg::idx_t'(sum - (sbfp_pkg::IDX_W + 1)'(sbfp_pkg::FRAME_BYTES));
		end else begin
			addr = sum[sbfp_pkg::IDX_W-1:0];
		end
		head_sum = {1'b0, head_q} + {1'b0, req.adv_by};
		if (head_sum >= (sbfp_pkg::IDX_W + 1)'(sbfp_pkg::FRAME_BYTES)) begin
			head_next = sbfp_pkg::idx_t'(head_sum - (sbfp_pkg::IDX_W + 1)'(sbfp_pkg::FRAME_BYTES));
		end else begin
			head_next = head_sum[sbfp_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (req.adv) begin
			head_q <= head_next;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata <= mem[addr];
		end
	end

endmodule

### rtl/core/sbus_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// sbus_frame_parser_unit
// SBUS receiver frame decoder: collects 25-byte frames, unpacks 16 channels.
// ----------------------------------------------------------------------------
// A byte that does not complete a frame is taken while the parser is idle.
// The byte that completes a frame starts a sequencer around the single-port
// frame memory (one access per cycle, registered read data): an accepted
// frame takes header checks, a load and a shift step for each of the 22
// channel bytes and an emit step per channel result, held by any output
// stall; a rejected frame takes header checks, a scan and a compare step
// per byte searched for the next start byte (up to 24 bytes) and a status
// result. Resync moves a head pointer, so no bytes are copied. Results sit
// in an output register; the next byte is taken while the last result waits.
// ----------------------------------------------------------------------------
module sbus_frame_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_ok,
	output logic [3:0]  channel_index,
	output logic [10:0] channel_value,
	output logic        digital_a,
	output logic        digital_b,
	output logic        lost_flag,
	output logic        failsafe_flag,
	output logic [31:0] accepted_total,
	output logic [31:0] rejected_total,
	output logic [31:0] discarded_total,
	output logic        last
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_HEAD   = 10'b00_0000_0010,
		ST_FLAGS  = 10'b00_0000_0100,
		ST_DECIDE = 10'b00_0000_1000,
		ST_LOAD   = 10'b00_0001_0000,
		ST_SHIFT  = 10'b00_0010_0000,
		ST_EMIT   = 10'b00_0100_0000,
		ST_SCAN   = 10'b00_1000_0000,
		ST_SCMP   = 10'b01_0000_0000,
		ST_STATUS = 10'b10_0000_0000
	} state_t;

	state_t                state_q;
	logic [7:0]            start_q;
	sbfp_pkg::idx_t        fill_q;
	sbfp_pkg::cnt_t        acc_cnt_q;
	sbfp_pkg::cnt_t        rej_cnt_q;
	sbfp_pkg::cnt_t        dis_cnt_q;
	logic [7:0]            end_q;
	logic [3:0]            flags_q;
	logic                  ok_q;
	sbfp_pkg::idx_t        pos_q;
	sbfp_pkg::acc_t        acc_q;
	sbfp_pkg::nbits_t      nbits_q;
	sbfp_pkg::ch_t         ch_q;

	sbfp_pkg::store_req_t  req;
	logic [7:0]            rdata;
	logic                  in_fire;
	logic                  slot_free;
	logic                  emit_fire;
	sbfp_pkg::nbits_t      nbits_add;

	sbfp_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid || out_ready;
	assign emit_fire = ((state_q == ST_EMIT) || (state_q == ST_STATUS)) && slot_free;
	assign nbits_add = nbits_q + sbfp_pkg::nbits_t'(8);

	always_comb begin
		req = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && !(fill_q == '0 && rx_byte != start_q)) begin
					req.wr    = 1'b1;
					req.pos   = fill_q;
					req.wdata = rx_byte;
				end
			end
			ST_HEAD: begin
				req.rd  = 1'b1;
				req.pos = sbfp_pkg::HEAD_POS;
			end
			ST_FLAGS: begin
				req.rd  = 1'b1;
				req.pos = sbfp_pkg::FLAG_POS;
			end
			ST_LOAD, ST_SCAN: begin
				req.rd  = 1'b1;
				req.pos = pos_q;
			end
			ST_SCMP: begin
				// found the next start byte: it becomes the new frame head
				if (rdata == start_q) begin
					req.adv    = 1'b1;
					req.adv_by = pos_q;
				end
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			start_q   <= sbfp_pkg::START_RESET;
			fill_q    <= '0;
			acc_cnt_q <= '0;
			rej_cnt_q <= '0;
			dis_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				start_q <= cfg_wr_data;
			end
			if (emit_fire) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (fill_q == '0 && rx_byte != start_q) begin
							dis_cnt_q <= dis_cnt_q + sbfp_pkg::cnt_t'(1);
						end else if (fill_q == sbfp_pkg::LAST_POS) begin
							fill_q  <= sbfp_pkg::FULL_FILL;
							state_q <= ST_HEAD;
						end else begin
							fill_q <= fill_q + sbfp_pkg::idx_t'(1);
						end
					end
				end
				ST_HEAD: begin
					state_q <= ST_FLAGS;
				end
				ST_FLAGS: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (ok_q) begin
						acc_cnt_q <= acc_cnt_q + sbfp_pkg::cnt_t'(1);
						fill_q    <= '0;
						state_q   <= ST_LOAD;
					end else begin
						rej_cnt_q <= rej_cnt_q + sbfp_pkg::cnt_t'(1);
						state_q   <= ST_SCAN;
					end
				end
				ST_LOAD: begin
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (nbits_add >= sbfp_pkg::nbits_t'(sbfp_pkg::CH_BITS)) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= (ch_q == sbfp_pkg::LAST_CH) ? ST_IDLE : ST_LOAD;
					end
				end
				ST_SCAN: begin
					state_q <= ST_SCMP;
				end
				ST_SCMP: begin
					if (rdata == start_q) begin
						dis_cnt_q <= dis_cnt_q + sbfp_pkg::cnt_t'(pos_q);
						fill_q    <= sbfp_pkg::FULL_FILL - pos_q;
						state_q   <= ST_STATUS;
					end else if (pos_q == sbfp_pkg::LAST_POS) begin
						// no start byte anywhere: the whole frame is dropped
						dis_cnt_q <= dis_cnt_q + sbfp_pkg::cnt_t'(sbfp_pkg::FRAME_BYTES);
						fill_q    <= '0;
						state_q   <= ST_STATUS;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_STATUS: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					end_q <= rx_byte;
				end
			end
			ST_FLAGS: begin
				ok_q <= (rdata == start_q) && sbfp_pkg::end_byte_ok(end_q);
			end
			ST_DECIDE: begin
				flags_q <= rdata[3:0];
				pos_q   <= sbfp_pkg::DATA_POS;
				acc_q   <= '0;
				nbits_q <= '0;
				ch_q    <= '0;
			end
			ST_SHIFT: begin
				// channel bits arrive lsb-first, append above what is held
				acc_q   <= acc_q | (sbfp_pkg::acc_t'(rdata) << nbits_q);
				nbits_q <= nbits_add;
				pos_q   <= pos_q + sbfp_pkg::idx_t'(1);
			end
			ST_EMIT: begin
				if (slot_free) begin
					frame_ok        <= 1'b1;
					channel_index   <= ch_q;
					channel_value   <= acc_q[sbfp_pkg::CH_BITS-1:0];
					digital_a       <= flags_q[0];
					digital_b       <= flags_q[1];
					lost_flag       <= flags_q[2];
					failsafe_flag   <= flags_q[3];
					accepted_total  <= acc_cnt_q;
					rejected_total  <= rej_cnt_q;
					discarded_total <= dis_cnt_q;
					last            <= (ch_q == sbfp_pkg::LAST_CH);
					acc_q           <= acc_q >> sbfp_pkg::CH_BITS;
					nbits_q         <= nbits_q - sbfp_pkg::nbits_t'(sbfp_pkg::CH_BITS);
					ch_q            <= ch_q + sbfp_pkg::ch_t'(1);
				end
			end
			ST_SCMP: begin
				if (rdata != start_q) begin
					pos_q <= pos_q + sbfp_pkg::idx_t'(1);
				end
			end
			ST_STATUS: begin
				if (slot_free) begin
					frame_ok        <= 1'b0;
					channel_index   <= '0;
					channel_value   <= '0;
					digital_a       <= 1'b0;
					digital_b       <= 1'b0;
					lost_flag       <= 1'b0;
					failsafe_flag   <= 1'b0;
					accepted_total  <= acc_cnt_q;
					rejected_total  <= rej_cnt_q;
					discarded_total <= dis_cnt_q;
					last            <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### tb/sbus_frame_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// sbus_frame_parser_unit_tb
// Self-checking bench for the sbus frame parser.
// Streams of good frames, broken frames and line noise are pushed through the
// byte port under several start bytes and handshake loads. A behavioral frame
// model predicts every channel and status beat, and each output beat is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sbus_frame_parser_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int SETTLE_WAIT  = 80;
	localparam int FB           = sbfp_pkg::FRAME_BYTES;
	localparam logic [7:0] END_MARKS [5] = '{8'h00, 8'h04, 8'h14, 8'h24, 8'h34};
	localparam logic [7:0] BAD_END   = 8'h01;

	typedef struct packed {
		logic                          ok;
		logic [3:0]                    idx;
		logic [sbfp_pkg::CH_BITS-1:0]  value;
		logic [3:0]                    flags;
		sbfp_pkg::cnt_t                acc;
		sbfp_pkg::cnt_t                rej;
		sbfp_pkg::cnt_t                disc;
		logic                          last;
	} chan_beat_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [7:0]         cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_ready;
	logic               frame_ok;
	logic [3:0]         channel_index;
	logic [10:0]        channel_value;
	logic               digital_a;
	logic               digital_b;
	logic               lost_flag;
	logic               failsafe_flag;
	logic [31:0]        accepted_total;
	logic [31:0]        rejected_total;
	logic [31:0]        discarded_total;
	logic               last;

	// frame model state
	logic [7:0]         model_store [FB];
	int                 model_fill;
	sbfp_pkg::cnt_t     model_acc;
	sbfp_pkg::cnt_t     model_rej;
	sbfp_pkg::cnt_t     model_disc;
	logic [7:0]         model_start;

	chan_beat_t         pending_beats [$];
	logic [7:0]         frame_buf [FB];
	int                 errors;
	int                 bytes_sent;
	int                 beats_seen;
	int                 cycle_count;
	int                 send_gap_pct;
	int                 sink_stall_pct;

	sbus_frame_parser_unit DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_ok        (frame_ok),
		.channel_index   (channel_index),
		.channel_value   (channel_value),
		.digital_a       (digital_a),
		.digital_b       (digital_b),
		.lost_flag       (lost_flag),
		.failsafe_flag   (failsafe_flag),
		.accepted_total  (accepted_total),
		.rejected_total  (rejected_total),
		.discarded_total (discarded_total),
		.last            (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d beats still pending", $time, pending_beats.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver side backpressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	function automatic logic end_mark_ok(input logic [7:0] b);
		logic ok;
		int k;
		ok = 1'b0;
		for (k = 0; k < 5; k++)
			if (b == END_MARKS[k])
				ok = 1'b1;
		return ok;
	endfunction

	// channels are packed lsb first starting at byte 1
	function automatic logic [sbfp_pkg::CH_BITS-1:0] unpack_chan(input int ch);
		int bitpos;
		int base;
		int k;
		logic [23:0] window;
		bitpos = ch * sbfp_pkg::CH_BITS;
		base   = 1 + bitpos / 8;
		window = '0;
		for (k = 0; k < 3; k++)
			if (base + k < FB)
				window = window | (24'(model_store[base + k]) << (8 * k));
		window = window >> (bitpos % 8);
		return window[sbfp_pkg::CH_BITS-1:0];
	endfunction

	task automatic predict_byte(input logic [7:0] b);
		chan_beat_t beat;
		int nxt;
		int c;
		int i;
		if (model_fill == 0 && b != model_start) begin
			model_disc = model_disc + 1;
			return;
		end
		if (model_fill >= FB)
			model_fill = 0;
		model_store[model_fill] = b;
		model_fill++;
		if (model_fill != FB)
			return;
		if (model_store[0] == model_start && end_mark_ok(model_store[FB-1])) begin
			model_acc  = model_acc + 1;
			model_fill = 0;
			for (c = 0; c < sbfp_pkg::CHANNELS; c++) begin
				beat       = '0;
				beat.ok    = 1'b1;
				beat.idx   = 4'(c);
				beat.value = unpack_chan(c);
				beat.flags = model_store[FB-2][3:0];
				beat.acc   = model_acc;
				beat.rej   = model_rej;
				beat.disc  = model_disc;
				beat.last  = (c == sbfp_pkg::CHANNELS - 1);
				pending_beats.push_back(beat);
			end
		end else begin
			// rejected: drop up to the next start byte and slide the rest down
			model_rej = model_rej + 1;
			nxt = 1;
			while (nxt < FB && model_store[nxt] != model_start)
				nxt++;
			model_disc = model_disc + 32'(nxt);
			if (nxt >= FB) begin
				model_fill = 0;
			end else begin
				model_fill = FB - nxt;
				for (i = 0; i < model_fill; i++)
					model_store[i] = model_store[nxt + i];
			end
			beat      = '0;
			beat.acc  = model_acc;
			beat.rej  = model_rej;
			beat.disc = model_disc;
			beat.last = 1'b1;
			pending_beats.push_back(beat);
		end
	endtask

	task automatic compare_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
		end
	endtask

	always @(posedge clk) begin : check_beats
		chan_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_seen++;
			if (pending_beats.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, actual index %0d value %0h",
					$time, channel_index, channel_value);
			end else begin
				want = pending_beats.pop_front();
				compare_field("frame_ok", want.ok, frame_ok);
				compare_field("channel_index", want.idx, channel_index);
				compare_field("channel_value", want.value, channel_value);
				compare_field("digital_a", want.flags[0], digital_a);
				compare_field("digital_b", want.flags[1], digital_b);
				compare_field("lost_flag", want.flags[2], lost_flag);
				compare_field("failsafe_flag", want.flags[3], failsafe_flag);
				compare_field("accepted_total", want.acc, accepted_total);
				compare_field("rejected_total", want.rej, rejected_total);
				compare_field("discarded_total", want.disc, discarded_total);
				compare_field("last", want.last, last);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
		predict_byte(b);
	endtask

	task automatic send_frame_buf(input int count);
		int i;
		for (i = 0; i < count; i++)
			send_byte(frame_buf[i]);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
	endtask

	// register writes only once the parser has gone quiet
	task automatic write_start_byte(input logic [7:0] value);
		drain_results();
		repeat (SETTLE_WAIT) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		model_start = value;
	endtask

	task automatic send_random_frame(input int start_pct, input int bad_end_pct);
		int i;
		frame_buf[0] = model_start;
		for (i = 1; i < FB - 1; i++)
			frame_buf[i] = ($urandom_range(99) < start_pct) ? model_start : 8'($urandom_range(255));
		frame_buf[FB-1] = ($urandom_range(99) < bad_end_pct) ?
			8'($urandom_range(255)) : END_MARKS[$urandom_range(4)];
		send_frame_buf(FB);
	endtask

	task automatic test_extreme_frames();
		int i;
		send_gap_pct   = 0;
		sink_stall_pct = 0;
		send_byte(8'h00);
		send_byte(8'hFF);
		// every channel at full scale, all flag bits set
		frame_buf[0] = model_start;
		for (i = 1; i < FB - 1; i++)
			frame_buf[i] = 8'hFF;
		frame_buf[FB-1] = END_MARKS[4];
		send_frame_buf(FB);
		// every channel at zero, no flags
		for (i = 1; i < FB - 1; i++)
			frame_buf[i] = 8'h00;
		frame_buf[FB-1] = END_MARKS[0];
		send_frame_buf(FB);
	endtask

	task automatic test_reject_resync();
		int i;
		// bad end byte with a start byte inside: resync at position 7
		frame_buf[0] = model_start;
		for (i = 1; i < FB; i++)
			frame_buf[i] = 8'h55;
		frame_buf[7] = model_start;
		frame_buf[FB-1] = BAD_END;
		send_frame_buf(FB);
		// the shifted remainder is completed into a good frame
		for (i = 0; i < 6; i++)
			frame_buf[i] = 8'hC3;
		frame_buf[6] = END_MARKS[3];
		send_frame_buf(7);
		// bad end and no start byte inside: whole frame dropped
		frame_buf[0] = model_start;
		for (i = 1; i < FB; i++)
			frame_buf[i] = 8'hAA;
		frame_buf[FB-1] = 8'hFF;
		send_frame_buf(FB);
	endtask

	task automatic test_start_change();
		int i;
		send_gap_pct   = 23;
		sink_stall_pct = 23;
		frame_buf[0] = model_start;
		for (i = 1; i < 10; i++)
			frame_buf[i] = 8'h11;
		send_frame_buf(10);
		// new start byte while a frame is half collected
		write_start_byte(8'hA5);
		for (i = 0; i < 15; i++)
			frame_buf[i] = 8'h22;
		frame_buf[2]  = 8'hA5;
		frame_buf[14] = END_MARKS[0];
		send_frame_buf(15);
		for (i = 0; i < 11; i++)
			frame_buf[i] = 8'h33;
		frame_buf[11] = END_MARKS[2];
		send_frame_buf(12);
	endtask

	task automatic test_random_phase(input logic [7:0] start, input int gap_pct,
			input int stall_pct, input int n_bytes);
		int sent;
		int roll;
		int k;
		int n_noise;
		write_start_byte(start);
		send_gap_pct   = gap_pct;
		sink_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_bytes) begin
			roll = $urandom_range(99);
			if (roll < 70) begin
				send_random_frame(2, 0);
				sent += FB;
			end else if (roll < 85) begin
				send_random_frame(12, 50);
				sent += FB;
			end else begin
				// line noise, may also open a frame by chance
				n_noise = $urandom_range(4, 1);
				for (k = 0; k < n_noise; k++)
					send_byte(8'($urandom_range(255)));
				sent += n_noise;
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		in_valid       = 1'b0;
		rx_byte        = '0;
		out_ready      = 1'b0;
		errors         = 0;
		bytes_sent     = 0;
		beats_seen     = 0;
		cycle_count    = 0;
		send_gap_pct   = 0;
		sink_stall_pct = 0;
		model_start    = sbfp_pkg::START_RESET;
		model_fill     = 0;
		model_acc      = '0;
		model_rej      = '0;
		model_disc     = '0;
		for (int i = 0; i < FB; i++)
			model_store[i] = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extreme_frames();
		test_reject_resync();
		test_start_change();
		test_random_phase(8'h00, 0, 0, 70);
		test_random_phase(8'hFF, 58, 0, 70);
		test_random_phase(8'($urandom_range(255)), 0, 58, 70);
		test_random_phase(8'($urandom_range(255)), 23, 23, 70);

		drain_results();
		repeat (SETTLE_WAIT) @(posedge clk);

		$display("bytes sent %0d, beats checked %0d, over four handshake loads",
			bytes_sent, beats_seen);
		$display("frames accepted %0d, rejected %0d, bytes dropped %0d",
			model_acc, model_rej, model_disc);
		if (errors == 0 && pending_beats.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
